// ----- hdl/lob_pkg.sv -----
`default_nettype none
package lob_pkg;
	localparam int MaxOrders = 256;
	localparam int IdxW = $clog2(MaxOrders);
	localparam int CntW = $clog2(MaxOrders + 1);
	localparam int PriceW = 10;
	localparam int QtyW = 16;
	localparam int IdW = 31;
	localparam int SeqW = 32;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_MARKET = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL = 3'd2,
		ST_DUP = 3'd3,
		ST_ZERO = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic side;
		logic [PriceW-1:0] price_tick;
		logic [QtyW-1:0] quantity;
		logic [IdW-1:0] order_id;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [QtyW-1:0] filled_qty;
		logic [8:0] live_orders;
	} out_word_t;

	typedef struct packed {
		logic side;
		logic [PriceW-1:0] price;
		logic [QtyW-1:0] qty;
		logic [IdW-1:0] id;
		logic [SeqW-1:0] seq;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_WRITE,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/lob_table.sv -----
`default_nettype none
module lob_table import lob_pkg::*; (
	input wire logic clk,
	input wire logic we,
	input wire logic [IdxW-1:0] waddr,
	input wire entry_t wdata,
	input wire logic [IdxW-1:0] raddr,
	output entry_t rdata
);
	entry_t mem [MaxOrders];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/limit_order_book_matcher_unit.sv -----
// Limit order book matcher with price-time priority.
// Input channel in_valid/in_ready carries one request word (add, cancel,
// market order); output channel out_valid/out_ready returns one result word
// per request: status, filled quantity and live order count.
// The table lives in a single-port-read memory swept one entry per cycle.
// Each request sweeps the table. Add, cancel and an unused request type
// make one sweep plus the write state before the result word is offered.
// A market order makes one sweep plus the fill state per resting order it
// fills, plus one more pass when it is not filled in full, before the
// result word is offered.
// One request is in flight at a time; in_ready is low from acceptance until
// the result word is taken.
// Reset clears all valid bits, the arrival counter and the live count; no
// clearing pass is needed. If the receiver stalls, the result word holds on
// out_word and no new request is taken.
`default_nettype none
module limit_order_book_matcher_unit import lob_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire in_word_t in_word,
	output logic out_valid,
	input wire logic out_ready,
	output out_word_t out_word
);
	state_t state_q, state_d;
	in_word_t req_q;
	logic [MaxOrders-1:0] valid_q;
	logic [SeqW-1:0] arrival_q;
	logic [CntW-1:0] live_q;
	logic [IdxW:0] scan_q;
	logic [IdxW-1:0] raddr;
	entry_t rdata;
	logic rd_live_q;
	logic [IdxW-1:0] rd_idx_q;
	logic found_q, free_found_q, best_found_q;
	logic [IdxW-1:0] hit_q, free_q, best_q;
	logic [PriceW-1:0] best_price_q;
	logic [SeqW-1:0] best_age_q;
	logic [QtyW-1:0] best_qty_q, remaining_q;
	logic [2:0] status_q;
	logic we;
	entry_t wdata;
	logic [IdxW-1:0] waddr;
	logic [SeqW-1:0] age;
	logic take;
	logic [QtyW-1:0] trade;
	logic opp_side;

	lob_table u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign raddr = scan_q[IdxW] ? best_q : scan_q[IdxW-1:0];
	assign opp_side = ~req_q.side;
	assign age = arrival_q - rdata.seq;
	assign trade = (remaining_q < best_qty_q) ? remaining_q : best_qty_q;

	always_comb begin
		if (!best_found_q) begin
			take = 1'b1;
		end else if (rdata.price != best_price_q) begin
			take = opp_side ? (rdata.price < best_price_q) : (rdata.price > best_price_q);
		end else begin
			take = age > best_age_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_SCAN;
			S_SCAN: if (scan_q[IdxW] && !rd_live_q) begin
				if (req_q.req_type == REQ_MARKET) state_d = S_FILL;
				else state_d = S_WRITE;
			end
			S_FILL: state_d = S_DONE;
			S_WRITE: state_d = S_DONE;
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_FILL && best_found_q && remaining_q != trade) state_d = S_SCAN;
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_DONE);
		out_word.status = status_q;
		out_word.filled_qty = req_q.quantity - remaining_q;
		out_word.live_orders = 9'(live_q);
		we = (state_q == S_WRITE) && (req_q.req_type == REQ_ADD) && (status_q == ST_OK);
		waddr = free_q;
		wdata.side = req_q.side;
		wdata.price = req_q.price_tick;
		wdata.qty = req_q.quantity;
		wdata.id = req_q.order_id;
		wdata.seq = arrival_q;
		if (state_q == S_FILL) begin
			we = best_found_q;
			waddr = best_q;
			wdata = rdata;
			wdata.qty = best_qty_q - trade;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			arrival_q <= '0;
			live_q <= '0;
			scan_q <= '0;
			rd_live_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					rd_live_q <= 1'b0;
				end
				S_SCAN: begin
					rd_live_q <= !scan_q[IdxW];
					rd_idx_q <= scan_q[IdxW-1:0];
					if (!scan_q[IdxW]) scan_q <= scan_q + 1'b1;
				end
				S_FILL: begin
					scan_q <= '0;
					rd_live_q <= 1'b0;
					if (best_found_q && best_qty_q == trade) begin
						valid_q[best_q] <= 1'b0;
						live_q <= live_q - 1'b1;
					end
				end
				S_WRITE: begin
					if (we) begin
						valid_q[free_q] <= 1'b1;
						arrival_q <= arrival_q + 1'b1;
						live_q <= live_q + 1'b1;
					end else if (req_q.req_type == REQ_CANCEL && found_q) begin
						valid_q[hit_q] <= 1'b0;
						live_q <= live_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q <= in_word;
				remaining_q <= in_word.quantity;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end
			S_SCAN: begin
				if (!rd_live_q) begin
				end else if (valid_q[rd_idx_q]) begin
					if (rdata.id == req_q.order_id && !found_q) begin
						found_q <= 1'b1;
						hit_q <= rd_idx_q;
					end
					if (rdata.side == opp_side && take) begin
						best_found_q <= 1'b1;
						best_q <= rd_idx_q;
						best_price_q <= rdata.price;
						best_age_q <= age;
						best_qty_q <= rdata.qty;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_q <= rd_idx_q;
				end
				if (scan_q[IdxW] && !rd_live_q) begin
					if (req_q.req_type == REQ_ADD && req_q.quantity == '0) status_q <= ST_ZERO;
					else if (req_q.req_type == REQ_ADD && found_q) status_q <= ST_DUP;
					else if (req_q.req_type == REQ_ADD && !free_found_q) status_q <= ST_FULL;
					else if (req_q.req_type == REQ_CANCEL && !found_q) status_q <= ST_NOT_FOUND;
					else status_q <= ST_OK;
				end
			end
			S_FILL: begin
				if (best_found_q) remaining_q <= remaining_q - trade;
				best_found_q <= 1'b0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/lob_checker.sv -----
`default_nettype none
module lob_checker import lob_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire out_word_t out_word
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request word dropped before acceptance");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while result pending");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status <= ST_ZERO)
		else $error("bad status code");
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.live_orders <= 9'(MaxOrders))
		else $error("live count out of range");
endmodule

bind limit_order_book_matcher_unit lob_checker u_lob_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
`default_nettype wire
